// ===== rtl/core/ggh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggh_pkg - go-to-goal heading controller package
// Field widths, fixed-point constants, register indexes and the CORDIC
// arctangent table of the controller; its checker shares the types and constants.
// ----------------------------------------------------------------------------
package ggh_pkg;

    // interface field widths
    localparam int COORD_W   = 32;
    localparam int ANGLE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 16;
    localparam int VEL_W     = 17;
    localparam int OMEGA_W   = 32;
    localparam int CFG_IDX_W = 2;

    // internal datapath widths
    localparam int CORDIC_W  = 56;    // x/y lanes, positions scaled by 2^20
    localparam int ZACC_W    = 35;    // angle accumulator, Q30
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = 5;

    localparam int POS_SHIFT   = 20;  // Q16.16 position into CORDIC lane
    localparam int ANGLE_SHIFT = 17;  // Q13 <-> Q30
    localparam int VEL_SHIFT   = 30;
    localparam int OMEGA_SHIFT = 5;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic signed [ANGLE_W:0]    angle_wide_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic signed [VEL_W-1:0]    vel_t;
    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [ZACC_W-1:0]   zacc_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    // angle constants
    localparam angle_t      PI_Q13      = 16'sd25736;
    localparam angle_wide_t TWO_PI_Q13  = 17'sd51472;
    localparam zacc_t       PI_Q30      = 35'sd3373259426;
    localparam zacc_t       HALF_PI_Q30 = 35'sd1686629713;

    // reciprocal of the CORDIC gain, Q30
    localparam logic signed [MUL_B_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

    // velocity clamp
    localparam vel_t VEL_MAX = 17'sd65535;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 2'd3;

    // register reset values
    localparam gain_t               GAIN_P_RESET = 16'sd128;
    localparam gain_t               GAIN_D_RESET = 16'sd0;
    localparam gain_t               GAIN_I_RESET = 16'sd0;
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd3277;

    // atan(2^-i) in Q30
    function automatic zacc_t atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        zacc_t val;
        begin
            case (idx)
                5'd0:    val = 35'sd843314857;
                5'd1:    val = 35'sd497837830;
                5'd2:    val = 35'sd263043837;
                5'd3:    val = 35'sd133525159;
                5'd4:    val = 35'sd67021687;
                5'd5:    val = 35'sd33543516;
                5'd6:    val = 35'sd16775851;
                5'd7:    val = 35'sd8388437;
                5'd8:    val = 35'sd4194283;
                5'd9:    val = 35'sd2097149;
                5'd10:   val = 35'sd1048576;
                5'd11:   val = 35'sd524288;
                5'd12:   val = 35'sd262144;
                5'd13:   val = 35'sd131072;
                5'd14:   val = 35'sd65536;
                5'd15:   val = 35'sd32768;
                5'd16:   val = 35'sd16384;
                5'd17:   val = 35'sd8192;
                5'd18:   val = 35'sd4096;
                5'd19:   val = 35'sd2048;
                5'd20:   val = 35'sd1024;
                5'd21:   val = 35'sd512;
                5'd22:   val = 35'sd256;
                5'd23:   val = 35'sd128;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/core/go_to_goal_heading_pid_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_heading_pid_unit - unicycle go-to-goal heading controller
// Stores the robot pose, and for each goal finds the bearing with a vectoring
// CORDIC, forms the wrapped heading error and a saturated PID turn rate, and
// resolves the forward speed along the heading with a rotating CORDIC.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  -------------------------------------------
//  input    in_valid / in_stall   operation, coord_x, coord_y, heading_in
//  output   out_valid / out_stall turn_rate, velocity_x, velocity_y,
//                                 heading_error
//  config   cfg_write             cfg_index, cfg_data
//
//  A pose item is taken while the block is idle and the block stays ready.
//  A goal item holds in_stall high until its result is loaded. N = min(CORDIC_STEPS,
//  24): one x/y/z CORDIC unit runs N steps for the bearing and N steps for the
//  velocity, and one 17x33 multiplier takes four products in turn.
//  The result sits in an output register; a new goal may start while it waits,
//  and only its final load waits for that register to empty.
//  Reset is asynchronous, active low, and restores the registers and pose.

module go_to_goal_heading_pid_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  logic [ggh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ggh_pkg::GAIN_W-1:0]     cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  ggh_pkg::coord_t                coord_x,
    input  ggh_pkg::coord_t                coord_y,
    input  ggh_pkg::angle_t                heading_in,

    output logic                           out_valid,
    input  logic                           out_stall,
    output ggh_pkg::coord_t                turn_rate,
    output ggh_pkg::vel_t                  velocity_x,
    output ggh_pkg::vel_t                  velocity_y,
    output ggh_pkg::angle_t                heading_error
);

    import ggh_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(STEPS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VINIT = 4'd1;
    localparam logic [3:0] S_VEC  = 4'd2;
    localparam logic [3:0] S_BEAR = 4'd3;
    localparam logic [3:0] S_ERR  = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ROT  = 4'd7;
    localparam logic [3:0] S_NEG  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // multiplier slots
    localparam logic [2:0] MUL_SPEED = 3'd0;
    localparam logic [2:0] MUL_P     = 3'd1;
    localparam logic [2:0] MUL_D     = 3'd2;
    localparam logic [2:0] MUL_I     = 3'd3;
    localparam logic [2:0] MUL_LAST  = 3'd4;

    localparam cordic_t VEL_HALF   = cordic_t'(1) <<< (VEL_SHIFT - 1);
    localparam zacc_t   BEAR_HALF  = zacc_t'(1) <<< (ANGLE_SHIFT - 1);
    localparam prod_t   OMEGA_HALF = prod_t'(1) <<< (OMEGA_SHIFT - 1);
    localparam prod_t   OMEGA_MAX  = prod_t'(coord_t'({1'b0, {(OMEGA_W-1){1'b1}}}));
    localparam prod_t   OMEGA_MIN  = prod_t'(coord_t'({1'b1, {(OMEGA_W-1){1'b0}}}));
    localparam logic signed [COORD_W:0] SUM_MAX = (COORD_W+1)'(OMEGA_MAX);
    localparam logic signed [COORD_W:0] SUM_MIN = (COORD_W+1)'(OMEGA_MIN);

    logic [3:0]            state_reg;
    logic [ATAN_IDX_W-1:0] step_reg;
    logic [2:0]            mul_cnt_reg;

    // configuration
    gain_t                 gain_p_reg;
    gain_t                 gain_d_reg;
    gain_t                 gain_i_reg;
    logic [SPEED_W-1:0]    speed_reg;

    // controller state
    coord_t                pose_x_reg;
    coord_t                pose_y_reg;
    angle_t                pose_heading_reg;
    angle_t                prev_err_reg;
    coord_t                error_sum_reg;

    // working registers
    coord_t                goal_x_reg;
    coord_t                goal_y_reg;
    logic                  zero_reg;
    logic                  neg_reg;
    cordic_t               cx_reg;
    cordic_t               cy_reg;
    zacc_t                 cz_reg;
    angle_t                bear_reg;
    angle_t                head_wrap_reg;
    angle_t                err_reg;
    angle_wide_t           de_reg;
    prod_t                 prod_reg;
    prod_t                 acc_reg;

    logic                  out_valid_reg;
    coord_t                turn_rate_reg;
    vel_t                  vel_x_reg;
    vel_t                  vel_y_reg;
    angle_t                heading_error_reg;

    // handshake
    logic in_take;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign turn_rate     = turn_rate_reg;
    assign velocity_x    = vel_x_reg;
    assign velocity_y    = vel_y_reg;
    assign heading_error = heading_error_reg;

    // goal offset, both senses, for the half-plane fold
    logic signed [COORD_W:0] dxp, dyp, dxn, dyn;

    assign dxp = (COORD_W+1)'(goal_x_reg) - (COORD_W+1)'(pose_x_reg);
    assign dyp = (COORD_W+1)'(goal_y_reg) - (COORD_W+1)'(pose_y_reg);
    assign dxn = (COORD_W+1)'(pose_x_reg) - (COORD_W+1)'(goal_x_reg);
    assign dyn = (COORD_W+1)'(pose_y_reg) - (COORD_W+1)'(goal_y_reg);

    // shared CORDIC step: shifters, table and three add/sub lanes
    cordic_t x_sh, y_sh;
    zacc_t   atan_val;
    logic    step_up;
    cordic_t cx_next, cy_next;
    zacc_t   cz_next;

    assign x_sh     = cx_reg >>> step_reg;
    assign y_sh     = cy_reg >>> step_reg;
    assign atan_val = atan_q30(step_reg);
    // vectoring drives y to zero, rotation drives z to zero
    assign step_up  = (state_reg == S_VEC) ? (!cy_reg[CORDIC_W-1] && (cy_reg != '0))
                                           : cz_reg[ZACC_W-1];
    assign cx_next  = step_up ? (cx_reg + y_sh) : (cx_reg - y_sh);
    assign cy_next  = step_up ? (cy_reg - x_sh) : (cy_reg + x_sh);
    assign cz_next  = step_up ? (cz_reg + atan_val) : (cz_reg - atan_val);

    // bearing: round Q30 to Q13 and clamp to +-pi
    zacc_t  bear_sh;
    angle_t bear_next;

    assign bear_sh = (cz_reg + BEAR_HALF) >>> ANGLE_SHIFT;

    always_comb
    begin
        if (zero_reg)
            bear_next = '0;
        else if (bear_sh > zacc_t'(PI_Q13))
            bear_next = PI_Q13;
        else if (bear_sh < -zacc_t'(PI_Q13))
            bear_next = -PI_Q13;
        else
            bear_next = ANGLE_W'(bear_sh);
    end

    // heading wrapped into +-pi for the velocity rotation
    angle_wide_t head_ext;
    angle_wide_t head_wrap_wide;

    assign head_ext = angle_wide_t'(pose_heading_reg);

    always_comb
    begin
        if (head_ext > angle_wide_t'(PI_Q13))
            head_wrap_wide = head_ext - TWO_PI_Q13;
        else if (head_ext < -angle_wide_t'(PI_Q13))
            head_wrap_wide = head_ext + TWO_PI_Q13;
        else
            head_wrap_wide = head_ext;
    end

    // heading error, wrapped into +-pi
    angle_wide_t err_raw;
    angle_wide_t err_wide;
    angle_t      err_next;

    assign err_raw = angle_wide_t'(bear_reg) - head_ext;

    always_comb
    begin
        if (err_raw > angle_wide_t'(PI_Q13))
            err_wide = err_raw - TWO_PI_Q13;
        else if (err_raw < -angle_wide_t'(PI_Q13))
            err_wide = err_raw + TWO_PI_Q13;
        else
            err_wide = err_raw;
    end

    assign err_next = ANGLE_W'(err_wide);

    // error change and saturated error sum
    angle_wide_t             de_next;
    logic signed [COORD_W:0] sum_wide;
    coord_t                  sum_next;

    assign de_next  = angle_wide_t'(err_reg) - angle_wide_t'(prev_err_reg);
    assign sum_wide = (COORD_W+1)'(error_sum_reg) + (COORD_W+1)'(err_reg);

    always_comb
    begin
        if (sum_wide > SUM_MAX)
            sum_next = coord_t'(OMEGA_MAX);
        else if (sum_wide < SUM_MIN)
            sum_next = coord_t'(OMEGA_MIN);
        else
            sum_next = COORD_W'(sum_wide);
    end

    // rotation start angle, folded into +-pi/2 when it is loaded
    zacc_t rot_z;

    assign rot_z = zacc_t'(head_wrap_reg) <<< ANGLE_SHIFT;

    // shared multiplier with operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    prod_t                     mul_prod;

    always_comb
    begin
        case (mul_cnt_reg)
            MUL_SPEED:
            begin
                mul_a = {1'b0, speed_reg};
                mul_b = GAIN_INV_Q30;
            end
            MUL_P:
            begin
                mul_a = MUL_A_W'(gain_p_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_D:
            begin
                mul_a = MUL_A_W'(gain_d_reg);
                mul_b = MUL_B_W'(de_reg);
            end
            MUL_I:
            begin
                mul_a = MUL_A_W'(gain_i_reg);
                mul_b = MUL_B_W'(error_sum_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // output rounding and clamps
    prod_t   omega_sh;
    coord_t  omega_next;
    cordic_t vx_sh, vy_sh;
    vel_t    vx_next, vy_next;

    assign omega_sh = (acc_reg + OMEGA_HALF) >>> OMEGA_SHIFT;
    assign vx_sh    = (cx_reg + VEL_HALF) >>> VEL_SHIFT;
    assign vy_sh    = (cy_reg + VEL_HALF) >>> VEL_SHIFT;

    always_comb
    begin
        if (omega_sh > OMEGA_MAX)
            omega_next = coord_t'(OMEGA_MAX);
        else if (omega_sh < OMEGA_MIN)
            omega_next = coord_t'(OMEGA_MIN);
        else
            omega_next = COORD_W'(omega_sh);

        if (vx_sh > cordic_t'(VEL_MAX))
            vx_next = VEL_MAX;
        else if (vx_sh < -cordic_t'(VEL_MAX))
            vx_next = -VEL_MAX;
        else
            vx_next = VEL_W'(vx_sh);

        if (vy_sh > cordic_t'(VEL_MAX))
            vy_next = VEL_MAX;
        else if (vy_sh < -cordic_t'(VEL_MAX))
            vy_next = -VEL_MAX;
        else
            vy_next = VEL_W'(vy_sh);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_d_reg <= GAIN_D_RESET;
            gain_i_reg <= GAIN_I_RESET;
            speed_reg  <= SPEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= gain_t'(cfg_data);
                REG_GAIN_D: gain_d_reg <= gain_t'(cfg_data);
                REG_GAIN_I: gain_i_reg <= gain_t'(cfg_data);
                REG_SPEED:  speed_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            mul_cnt_reg      <= MUL_SPEED;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            prev_err_reg     <= '0;
            error_sum_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // output slot empties when taken
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (operation)
                            state_reg <= S_VINIT;
                        else
                        begin
                            pose_x_reg       <= coord_x;
                            pose_y_reg       <= coord_y;
                            pose_heading_reg <= heading_in;
                        end
                    end
                end
                S_VINIT:
                begin
                    step_reg  <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= S_BEAR;
                end
                S_BEAR:
                    state_reg <= S_ERR;
                S_ERR:
                    state_reg <= S_UPD;
                S_UPD:
                begin
                    error_sum_reg <= sum_next;
                    prev_err_reg  <= err_reg;
                    mul_cnt_reg   <= MUL_SPEED;
                    state_reg     <= S_MUL;
                end
                S_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == MUL_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                        state_reg <= S_NEG;
                end
                S_NEG:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_take && operation)
                begin
                    goal_x_reg <= coord_x;
                    goal_y_reg <= coord_y;
                end
            end
            S_VINIT:
            begin
                zero_reg <= (dxp == '0) && (dyp == '0);
                // left half-plane: rotate by pi first
                if (dxp[COORD_W])
                begin
                    cx_reg <= cordic_t'(dxn) <<< POS_SHIFT;
                    cy_reg <= cordic_t'(dyn) <<< POS_SHIFT;
                    cz_reg <= dyp[COORD_W] ? -PI_Q30 : PI_Q30;
                end
                else
                begin
                    cx_reg <= cordic_t'(dxp) <<< POS_SHIFT;
                    cy_reg <= cordic_t'(dyp) <<< POS_SHIFT;
                    cz_reg <= '0;
                end
            end
            S_VEC, S_ROT:
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
            end
            S_BEAR:
            begin
                bear_reg      <= bear_next;
                head_wrap_reg <= ANGLE_W'(head_wrap_wide);
            end
            S_ERR:
                err_reg <= err_next;
            S_UPD:
            begin
                de_reg <= de_next;
                // fold into +-pi/2 and remember to negate the result
                if (rot_z > HALF_PI_Q30)
                begin
                    cz_reg  <= rot_z - PI_Q30;
                    neg_reg <= 1'b1;
                end
                else if (rot_z < -HALF_PI_Q30)
                begin
                    cz_reg  <= rot_z + PI_Q30;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    cz_reg  <= rot_z;
                    neg_reg <= 1'b0;
                end
            end
            S_MUL:
            begin
                prod_reg <= mul_prod;
                // consume the product from the previous slot
                case (mul_cnt_reg)
                    MUL_P:
                    begin
                        cx_reg <= cordic_t'(prod_reg);
                        cy_reg <= '0;
                    end
                    MUL_D:
                        acc_reg <= prod_reg;
                    MUL_I, MUL_LAST:
                        acc_reg <= acc_reg + prod_reg;
                    default:
                        ;
                endcase
            end
            S_NEG:
            begin
                if (neg_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    turn_rate_reg     <= omega_next;
                    vel_x_reg         <= vx_next;
                    vel_y_reg         <= vy_next;
                    heading_error_reg <= err_reg;
                end
            end
            default:
                ;
        endcase
    end

endmodule

// ===== rtl/core/ggh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggh_checker - port-level checks for the go-to-goal controller
// Watches the top level's ports: result ranges, output hold under stall and
// the busy behaviour after goal and pose items.
// ----------------------------------------------------------------------------
module ggh_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             operation,
    input  logic             out_valid,
    input  logic             out_stall,
    input  ggh_pkg::coord_t  turn_rate,
    input  ggh_pkg::vel_t    velocity_x,
    input  ggh_pkg::vel_t    velocity_y,
    input  ggh_pkg::angle_t  heading_error
);

    import ggh_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(turn_rate)
            && $stable(velocity_x) && $stable(velocity_y) && $stable(heading_error))
        else $error("result changed while stalled");

    // the reported error is wrapped
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_error <= PI_Q13) && (heading_error >= -PI_Q13))
        else $error("heading error outside +-pi");

    // velocity components are clamped
    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (velocity_x <= VEL_MAX) && (velocity_x >= -VEL_MAX)
            && (velocity_y <= VEL_MAX) && (velocity_y >= -VEL_MAX))
        else $error("velocity outside clamp");

    // a goal item makes the block busy
    a_goal_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation |=> in_stall)
        else $error("goal item did not start the sequencer");

    // a pose item leaves the block ready
    a_pose_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !operation |=> !in_stall)
        else $error("pose item stalled the input");

endmodule

bind go_to_goal_heading_pid_unit ggh_checker u_ggh_checker (.*);
